FILE: hw/rtl/assert_macros.svh
// assertion macros shared by the rtl modules
// no dependencies; each file that asserts includes this header
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every edge out of reset
`define CHK_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequent holds in the same cycle
`define CHK_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent holds in the next cycle
`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/fcspq_pkg.sv
// types, codes and constants of the four class priority queue
// no dependencies; used by every module of the block
package fcspq_pkg;

   localparam int CLASS_DEPTH_DEFAULT = 256;
   localparam int NUM_CLASSES_DEFAULT = 4;
   localparam int QUEUE_DEPTH         = 2;

   localparam int CLASS_W = 2;
   localparam int BYTES_W = 16;
   localparam int TAG_W   = 16;
   localparam int PS_W    = 16;
   localparam int WAIT_W  = 48;
   localparam int TOTAL_W = 26;
   localparam int ENTRY_W = TAG_W + BYTES_W;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [PS_W-1:0]    PS_PER_BYTE_RESET = 16'd800;
   localparam logic [CLASS_W-1:0] LONG_HDR_RESET    = 2'd3;
   localparam logic [CLASS_W-1:0] LONG_RETX_RESET   = 2'd2;
   localparam logic [CLASS_W-1:0] LONG_DATA_RESET   = 2'd1;

   localparam logic [CLASS_W-1:0] CLASS_TOP  = 2'd3;
   localparam logic [CLASS_W-1:0] CLASS_RETX = 2'd2;
   localparam logic [CLASS_W-1:0] CLASS_DATA = 2'd1;

   typedef enum logic {
      CMD_ENQUEUE = 1'b0,
      CMD_DEQUEUE = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      KIND_CONTROL = 2'd0,
      KIND_NDP     = 2'd1,
      KIND_OTHER   = 2'd2,
      KIND_UNKNOWN = 2'd3
   } kind_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PS_PER_BYTE = 2'd0,
      CSR_LONG_HDR    = 2'd1,
      CSR_LONG_RETX   = 2'd2,
      CSR_LONG_DATA   = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_READ,
      BK_SUM,
      BK_MUL,
      BK_DONE
   } back_state_type;

   typedef struct packed {
      logic               command;
      logic [1:0]         packet_kind;
      logic               hdr_trimmed;
      logic               retransmitted;
      logic               long_flow;
      logic [BYTES_W-1:0] packet_bytes;
      logic [TAG_W-1:0]   packet_tag;
   } req_type;

   typedef struct packed {
      logic               accepted;
      logic               dropped;
      logic               kind_error;
      logic [CLASS_W-1:0] assigned_class;
      logic [WAIT_W-1:0]  wait_ps;
      logic               out_valid;
      logic [TAG_W-1:0]   out_tag;
      logic [BYTES_W-1:0] out_bytes;
      logic [CLASS_W-1:0] out_class;
      logic [TOTAL_W-1:0] total_bytes;
   } rsp_type;

   typedef struct packed {
      logic [CLASS_W-1:0] long_header_class;
      logic [CLASS_W-1:0] long_retx_class;
      logic [CLASS_W-1:0] long_data_class;
   } cls_cfg_type;

   // classified word handed from front to back
   typedef struct packed {
      logic               command;
      logic               kind_error;
      logic [CLASS_W-1:0] cls;
      logic [BYTES_W-1:0] packet_bytes;
      logic [TAG_W-1:0]   packet_tag;
   } work_type;

   typedef struct packed {
      logic     valid;
      work_type word;
   } work_chan_type;

endpackage

FILE: hw/rtl/fcspq_front.sv
// front stage: accepts request words and classifies them
// depends on fcspq_pkg
module fcspq_front #(
   parameter int NUM_CLASSES = fcspq_pkg::NUM_CLASSES_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  fcspq_pkg::cls_cfg_type cfg,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  fcspq_pkg::req_type     req_data,
   output fcspq_pkg::work_chan_type push,
   input  logic                   push_ready
);

   logic                   valid_ff, valid_in;
   fcspq_pkg::work_type    word_ff, word_in;
   logic [fcspq_pkg::CLASS_W-1:0] raw_cls;

   assign req_ready  = !valid_ff || push_ready;
   assign push.valid = valid_ff;
   assign push.word  = word_ff;

   always_comb begin
      raw_cls = fcspq_pkg::CLASS_DATA;
      case (req_data.packet_kind)
         fcspq_pkg::KIND_CONTROL: raw_cls = fcspq_pkg::CLASS_TOP;
         fcspq_pkg::KIND_NDP: begin
            if (req_data.hdr_trimmed) begin
               raw_cls = req_data.long_flow ? cfg.long_header_class : fcspq_pkg::CLASS_TOP;
            end else if (req_data.retransmitted) begin
               raw_cls = req_data.long_flow ? cfg.long_retx_class : fcspq_pkg::CLASS_RETX;
            end else begin
               raw_cls = req_data.long_flow ? cfg.long_data_class : fcspq_pkg::CLASS_DATA;
            end
         end
         fcspq_pkg::KIND_OTHER: raw_cls = fcspq_pkg::CLASS_DATA;
         default: raw_cls = '0;
      endcase
   end

   always_comb begin
      word_in              = word_ff;
      word_in.command      = req_data.command;
      word_in.kind_error   = (req_data.packet_kind == fcspq_pkg::KIND_UNKNOWN);
      word_in.packet_bytes = req_data.packet_bytes;
      word_in.packet_tag   = req_data.packet_tag;
      // saturate to the top class that exists
      if (int'(raw_cls) >= NUM_CLASSES) begin
         word_in.cls = fcspq_pkg::CLASS_W'(NUM_CLASSES - 1);
      end else begin
         word_in.cls = raw_cls;
      end
      if (req_data.packet_kind == fcspq_pkg::KIND_UNKNOWN) begin
         word_in.cls = '0;
      end
      valid_in = valid_ff;
      if (req_valid && req_ready) begin
         valid_in = 1'b1;
      end else if (push_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         word_ff <= word_in;
      end
   end

endmodule

FILE: hw/rtl/fcspq_queue.sv
// short queue of classified words between front and back
// depends on fcspq_pkg and assert_macros.svh
`include "assert_macros.svh"
module fcspq_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  fcspq_pkg::work_chan_type push,
   output logic                     push_ready,
   output fcspq_pkg::work_chan_type pop,
   input  logic                     pop_ready
);

   localparam int DEPTH = fcspq_pkg::QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   fcspq_pkg::work_type slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop.valid  = (count_ff != '0);
   assign pop.word   = slot_ff[rd_ptr_ff];
   assign do_push    = push.valid && push_ready;
   assign do_pop     = pop.valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push.word;
      end
   end

   `CHK_ALWAYS(a_count_bound, clock, reset, count_ff <= CNT_W'(DEPTH), "queue count overrun")
   `CHK_NEXT(a_push_grows, clock, reset, do_push && !do_pop, count_ff == $past(count_ff) + 1'b1, "push lost")
   `CHK_NEXT(a_pop_shrinks, clock, reset, do_pop && !do_push, count_ff == $past(count_ff) - 1'b1, "pop lost")

endmodule

FILE: hw/rtl/fcspq_back.sv
// back end: class fifos, byte counters, wait estimate and result register
// depends on fcspq_pkg and assert_macros.svh
`include "assert_macros.svh"
module fcspq_back #(
   parameter int CLASS_DEPTH = fcspq_pkg::CLASS_DEPTH_DEFAULT,
   parameter int NUM_CLASSES = fcspq_pkg::NUM_CLASSES_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [fcspq_pkg::PS_W-1:0]    ps_per_byte,
   input  fcspq_pkg::work_chan_type      pop,
   output logic                          pop_ready,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output fcspq_pkg::rsp_type            rsp_data
);

   localparam int CLS_W  = $clog2(NUM_CLASSES);
   localparam int PTR_W  = (CLASS_DEPTH > 1) ? $clog2(CLASS_DEPTH) : 1;
   localparam int CNT_W  = $clog2(CLASS_DEPTH + 1);
   localparam int CB_W   = fcspq_pkg::BYTES_W + CNT_W;
   localparam int SUM_W  = CB_W + CLS_W;
   localparam int PROD_W = SUM_W + fcspq_pkg::PS_W;
   localparam int ADDR_W = CLS_W + PTR_W;
   localparam int MEM_DEPTH = 1 << ADDR_W;
   localparam int BW = fcspq_pkg::BYTES_W;

   fcspq_pkg::back_state_type state_ff, state_in;

   logic [PTR_W-1:0] head_ff [NUM_CLASSES];
   logic [PTR_W-1:0] head_in [NUM_CLASSES];
   logic [PTR_W-1:0] tail_ff [NUM_CLASSES];
   logic [PTR_W-1:0] tail_in [NUM_CLASSES];
   logic [CNT_W-1:0] count_ff [NUM_CLASSES];
   logic [CNT_W-1:0] count_in [NUM_CLASSES];
   logic [CB_W-1:0]  cbytes_ff [NUM_CLASSES];
   logic [CB_W-1:0]  cbytes_in [NUM_CLASSES];
   logic [SUM_W-1:0] total_ff, total_in;

   fcspq_pkg::work_type cur_ff, cur_in;
   fcspq_pkg::rsp_type  res_ff, res_in;
   fcspq_pkg::rsp_type  rsp_ff, rsp_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [CLS_W-1:0]    sel_ff, sel_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;

   logic [fcspq_pkg::ENTRY_W-1:0] mem [MEM_DEPTH];
   logic [fcspq_pkg::ENTRY_W-1:0] rd_data_ff;
   logic                          mem_we, mem_re;
   logic [ADDR_W-1:0]             mem_addr;
   logic [fcspq_pkg::ENTRY_W-1:0] mem_wdata;

   logic [CLS_W-1:0]  enq_cls, cur_cls, found_cls;
   logic              found;
   logic [BW-1:0]     rd_bytes;
   logic [PROD_W-1:0] prod;
   logic [SUM_W-1:0]  sum_all;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign pop_ready = (state_ff == fcspq_pkg::BK_IDLE);
   assign enq_cls   = CLS_W'(pop.word.cls);
   assign cur_cls   = CLS_W'(cur_ff.cls);
   assign rd_bytes  = rd_data_ff[BW-1:0];
   assign prod      = PROD_W'(sum_ff) * PROD_W'(ps_per_byte);

   // highest class holding an entry
   always_comb begin
      found     = 1'b0;
      found_cls = '0;
      for (int c = 0; c < NUM_CLASSES; c++) begin
         if (count_ff[c] != '0) begin
            found     = 1'b1;
            found_cls = CLS_W'(c);
         end
      end
   end

   always_comb begin
      sum_all = '0;
      for (int c = 0; c < NUM_CLASSES; c++) begin
         sum_all = sum_all + SUM_W'(cbytes_ff[c]);
      end
   end

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      cbytes_in    = cbytes_ff;
      total_in     = total_ff;
      cur_in       = cur_ff;
      res_in       = res_ff;
      sel_in       = sel_ff;
      sum_in       = sum_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      mem_addr     = '0;
      mem_wdata    = {pop.word.packet_tag, pop.word.packet_bytes};

      case (state_ff)
         fcspq_pkg::BK_IDLE: begin
            if (pop.valid) begin
               cur_in = pop.word;
               res_in = '0;
               if (pop.word.command == fcspq_pkg::CMD_ENQUEUE) begin
                  if (pop.word.kind_error) begin
                     res_in.kind_error = 1'b1;
                     state_in          = fcspq_pkg::BK_DONE;
                  end else begin
                     res_in.assigned_class = pop.word.cls;
                     if (count_ff[enq_cls] >= CNT_W'(CLASS_DEPTH)) begin
                        res_in.dropped = 1'b1;
                     end else begin
                        mem_we             = 1'b1;
                        mem_addr           = {enq_cls, tail_ff[enq_cls]};
                        tail_in[enq_cls]   = (tail_ff[enq_cls] == PTR_W'(CLASS_DEPTH - 1))
                                             ? '0 : tail_ff[enq_cls] + 1'b1;
                        count_in[enq_cls]  = count_ff[enq_cls] + 1'b1;
                        cbytes_in[enq_cls] = cbytes_ff[enq_cls] + CB_W'(pop.word.packet_bytes);
                        total_in           = total_ff + SUM_W'(pop.word.packet_bytes);
                        res_in.accepted    = 1'b1;
                     end
                     state_in = fcspq_pkg::BK_SUM;
                  end
               end else begin
                  if (found) begin
                     mem_re              = 1'b1;
                     mem_addr            = {found_cls, head_ff[found_cls]};
                     head_in[found_cls]  = (head_ff[found_cls] == PTR_W'(CLASS_DEPTH - 1))
                                           ? '0 : head_ff[found_cls] + 1'b1;
                     count_in[found_cls] = count_ff[found_cls] - 1'b1;
                     sel_in              = found_cls;
                     state_in            = fcspq_pkg::BK_READ;
                  end else begin
                     state_in = fcspq_pkg::BK_DONE;
                  end
               end
            end
         end
         fcspq_pkg::BK_READ: begin
            cbytes_in[sel_ff] = (cbytes_ff[sel_ff] >= CB_W'(rd_bytes))
                                ? cbytes_ff[sel_ff] - CB_W'(rd_bytes) : '0;
            total_in         = total_ff - SUM_W'(rd_bytes);
            res_in.out_valid = 1'b1;
            res_in.out_tag   = rd_data_ff[fcspq_pkg::ENTRY_W-1:BW];
            res_in.out_bytes = rd_bytes;
            res_in.out_class = fcspq_pkg::CLASS_W'(sel_ff);
            state_in         = fcspq_pkg::BK_DONE;
         end
         fcspq_pkg::BK_SUM: begin
            // bytes of this class and all above it
            sum_in = '0;
            for (int c = 0; c < NUM_CLASSES; c++) begin
               if (CLS_W'(c) >= cur_cls) begin
                  sum_in = sum_in + SUM_W'(cbytes_ff[c]);
               end
            end
            state_in = fcspq_pkg::BK_MUL;
         end
         fcspq_pkg::BK_MUL: begin
            res_in.wait_ps = fcspq_pkg::WAIT_W'(prod);
            state_in       = fcspq_pkg::BK_DONE;
         end
         fcspq_pkg::BK_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in             = res_ff;
               rsp_in.total_bytes = fcspq_pkg::TOTAL_W'(total_ff);
               rsp_valid_in       = 1'b1;
               state_in           = fcspq_pkg::BK_IDLE;
            end
         end
         default: state_in = fcspq_pkg::BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fcspq_pkg::BK_IDLE;
         rsp_valid_ff <= 1'b0;
         total_ff     <= '0;
         for (int c = 0; c < NUM_CLASSES; c++) begin
            head_ff[c]   <= '0;
            tail_ff[c]   <= '0;
            count_ff[c]  <= '0;
            cbytes_ff[c] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         total_ff     <= total_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         cbytes_ff    <= cbytes_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      res_ff <= res_in;
      sel_ff <= sel_in;
      sum_ff <= sum_in;
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= mem[mem_addr];
      end
   end

   `CHK_ALWAYS(a_total_matches, clock, reset, total_ff == sum_all, "total out of step with classes")
   `CHK_IMPLY(a_enq_outcome, clock, reset, rsp_valid_ff, !(rsp_ff.accepted && rsp_ff.dropped), "accepted and dropped")
   `CHK_IMPLY(a_deq_clean, clock, reset, rsp_valid_ff && rsp_ff.out_valid, !rsp_ff.accepted && !rsp_ff.dropped && !rsp_ff.kind_error, "dequeue word carries enqueue flags")

endmodule

FILE: hw/rtl/four_class_strict_priority_queue_unit.sv
// top level of the four class strict priority descriptor queue
// depends on fcspq_pkg, fcspq_front, fcspq_queue and fcspq_back
//
//   port group   dir   handshake          word
//   req_         in    valid / ready      fcspq_pkg::req_type
//   rsp_         out   valid / ready      fcspq_pkg::rsp_type
//   csr_         in    write enable only  index and 16 bit data
//
// a word passes the front register and a queue slot before the back end takes it;
// the back sequencer, with a single entry memory port, steps an enqueue through sum,
// mul and done, a dequeue through read and done, an unknown kind or empty via done
// reset is synchronous and clears pointers, counts and byte counters at once
// the queue lets the front keep accepting while a result waits on rsp_ready
module four_class_strict_priority_queue_unit #(
   parameter int CLASS_DEPTH = fcspq_pkg::CLASS_DEPTH_DEFAULT,
   parameter int NUM_CLASSES = fcspq_pkg::NUM_CLASSES_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  fcspq_pkg::req_type                  req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output fcspq_pkg::rsp_type                  rsp_data,
   input  logic                                csr_write_en,
   input  logic [fcspq_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [fcspq_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   logic [fcspq_pkg::PS_W-1:0] ps_per_byte_ff;
   fcspq_pkg::cls_cfg_type     cls_cfg_ff;
   fcspq_pkg::work_chan_type   push, pop;
   logic                       push_ready, pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         ps_per_byte_ff               <= fcspq_pkg::PS_PER_BYTE_RESET;
         cls_cfg_ff.long_header_class <= fcspq_pkg::LONG_HDR_RESET;
         cls_cfg_ff.long_retx_class   <= fcspq_pkg::LONG_RETX_RESET;
         cls_cfg_ff.long_data_class   <= fcspq_pkg::LONG_DATA_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            fcspq_pkg::CSR_PS_PER_BYTE: ps_per_byte_ff <= csr_wdata[fcspq_pkg::PS_W-1:0];
            fcspq_pkg::CSR_LONG_HDR:
               cls_cfg_ff.long_header_class <= csr_wdata[fcspq_pkg::CLASS_W-1:0];
            fcspq_pkg::CSR_LONG_RETX:
               cls_cfg_ff.long_retx_class <= csr_wdata[fcspq_pkg::CLASS_W-1:0];
            fcspq_pkg::CSR_LONG_DATA:
               cls_cfg_ff.long_data_class <= csr_wdata[fcspq_pkg::CLASS_W-1:0];
            default: ;
         endcase
      end
   end

   fcspq_front #(
      .NUM_CLASSES (NUM_CLASSES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cls_cfg_ff),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .push       (push),
      .push_ready (push_ready)
   );

   fcspq_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_ready (push_ready),
      .pop        (pop),
      .pop_ready  (pop_ready)
   );

   fcspq_back #(
      .CLASS_DEPTH (CLASS_DEPTH),
      .NUM_CLASSES (NUM_CLASSES)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .ps_per_byte (ps_per_byte_ff),
      .pop         (pop),
      .pop_ready   (pop_ready),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

endmodule
